// ----- src/cmi_pkg.sv -----
// Shared types and constants for the color map interpolator.
// Used by the core, select, blend and divider modules; depends on nothing else.
`timescale 1ns / 1ps
package cmi_pkg;

  // Number of stop registers, fixed by the register map.
  localparam int STOP_REGS      = 6;
  localparam int STOP_IDX_BITS  = 3;
  localparam int CFG_INDEX_BITS = 4;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAP_MODE   = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STOP_COUNT = 4'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STOP_BASE  = 4'd2;

  // Map modes.
  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_STEP   = 1'b1;

  localparam logic [2:0] COUNT_RESET = 3'd3;

  // Reset colors of the first three stops, given at 8 bits per channel.
  localparam logic [7:0] STOP0_RED   = 8'h33;
  localparam logic [7:0] STOP0_GREEN = 8'h40;
  localparam logic [7:0] STOP0_BLUE  = 8'hBF;
  localparam logic [7:0] STOP1_RED   = 8'hD9;
  localparam logic [7:0] STOP1_GREEN = 8'hD9;
  localparam logic [7:0] STOP1_BLUE  = 8'hD9;
  localparam logic [7:0] STOP2_RED   = 8'hE6;
  localparam logic [7:0] STOP2_GREEN = 8'h26;
  localparam logic [7:0] STOP2_BLUE  = 8'h1A;

  // Control that travels with each request between pipeline sections.
  typedef struct packed {
    logic valid;
    logic direct;   // result is a stop color, no blend needed
  } cmi_ctl_t;

endpackage

// ----- src/color_map_interpolator_core.sv -----
// Throughput: one sample per cycle; the output stalls only on out_ready, and
// bubbles in the pipeline still take new requests while a result waits.
// Depth is set by the restoring divider, one quotient bit per stage.
// Reset (rst_n low, synchronous) empties the pipeline and loads register defaults.
// Depends on cmi_pkg, cmi_select, cmi_blend and cmi_div.
`timescale 1ns / 1ps
module color_map_interpolator_core #(
  parameter int MAX_STOPS    = 6,
  parameter int SAMPLE_BITS  = 16,
  parameter int CHANNEL_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [SAMPLE_BITS-1:0]                 in_sample,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [CHANNEL_BITS-1:0]                out_red,
  output logic [CHANNEL_BITS-1:0]                out_green,
  output logic [CHANNEL_BITS-1:0]                out_blue,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [cmi_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [SAMPLE_BITS+3*CHANNEL_BITS-1:0]  cfg_data
);

  localparam int STOP_W = SAMPLE_BITS + 3 * CHANNEL_BITS;
  localparam int NW     = SAMPLE_BITS + CHANNEL_BITS + 2;
  localparam logic [SAMPLE_BITS-1:0] POS_ZERO = '0;
  localparam logic [SAMPLE_BITS-1:0] POS_MID  = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] POS_FULL = '1;

  // Scale an 8-bit reset color to the channel width.
  function automatic logic [CHANNEL_BITS-1:0] scale_ch(input logic [7:0] c);
    logic [19:0] w;
    w = {c, 12'd0};
    return w[19 -: CHANNEL_BITS];
  endfunction

  logic                                       map_mode_r;
  logic [2:0]                                 stop_count_r;
  logic [cmi_pkg::STOP_REGS-1:0][STOP_W-1:0]  stops_r;
  logic [cmi_pkg::CFG_INDEX_BITS-1:0]         stop_off;

  cmi_pkg::cmi_ctl_t            sel_ctl;
  cmi_pkg::cmi_ctl_t            bl_ctl;
  logic                         bl_ready;
  logic                         div_ready;
  logic [2:0][CHANNEL_BITS-1:0] sel_lo;
  logic [2:0][CHANNEL_BITS-1:0] sel_hi;
  logic [SAMPLE_BITS-1:0]       sel_span;
  logic [SAMPLE_BITS-1:0]       sel_off;
  logic [SAMPLE_BITS-1:0]       sel_rem;
  logic [2:0][NW-1:0]           bl_num;
  logic [SAMPLE_BITS-1:0]       bl_span;
  logic [2:0][CHANNEL_BITS-1:0] bl_col;
  logic [2:0][CHANNEL_BITS-1:0] quot;

  assign cfg_ready = 1'b1;
  assign stop_off  = cfg_index - cmi_pkg::REG_STOP_BASE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_mode_r   <= cmi_pkg::MODE_LINEAR;
      stop_count_r <= cmi_pkg::COUNT_RESET;
      stops_r[0]   <= {POS_ZERO, scale_ch(cmi_pkg::STOP0_RED),
                       scale_ch(cmi_pkg::STOP0_GREEN), scale_ch(cmi_pkg::STOP0_BLUE)};
      stops_r[1]   <= {POS_MID, scale_ch(cmi_pkg::STOP1_RED),
                       scale_ch(cmi_pkg::STOP1_GREEN), scale_ch(cmi_pkg::STOP1_BLUE)};
      stops_r[2]   <= {POS_FULL, scale_ch(cmi_pkg::STOP2_RED),
                       scale_ch(cmi_pkg::STOP2_GREEN), scale_ch(cmi_pkg::STOP2_BLUE)};
      for (int k = 3; k < cmi_pkg::STOP_REGS; k++) begin
        stops_r[k] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == cmi_pkg::REG_MAP_MODE) begin
        map_mode_r <= cfg_data[0];
      end else if (cfg_index == cmi_pkg::REG_STOP_COUNT) begin
        stop_count_r <= cfg_data[2:0];
      end else if (stop_off < cmi_pkg::CFG_INDEX_BITS'(cmi_pkg::STOP_REGS)) begin
        // Indexes past the last stop register give offsets of STOP_REGS or more and are dropped.
        stops_r[stop_off[cmi_pkg::STOP_IDX_BITS-1:0]] <= cfg_data;
      end
    end
  end

  cmi_select #(
    .MAX_STOPS   (MAX_STOPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_select (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .map_mode   (map_mode_r),
    .stop_count (stop_count_r),
    .stops      (stops_r),
    .ctl_o      (sel_ctl),
    .ready_i    (bl_ready),
    .lo_color_o (sel_lo),
    .hi_color_o (sel_hi),
    .span_o     (sel_span),
    .offset_o   (sel_off),
    .remain_o   (sel_rem)
  );

  cmi_blend #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (sel_ctl),
    .ready_o    (bl_ready),
    .lo_color_i (sel_lo),
    .hi_color_i (sel_hi),
    .span_i     (sel_span),
    .offset_i   (sel_off),
    .remain_i   (sel_rem),
    .ctl_o      (bl_ctl),
    .ready_i    (div_ready),
    .num_o      (bl_num),
    .span_o     (bl_span),
    .color_o    (bl_col)
  );

  cmi_div #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (bl_ctl),
    .ready_o   (div_ready),
    .num_i     (bl_num),
    .span_i    (bl_span),
    .color_i   (bl_col),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .quot_o    (quot)
  );

  assign out_red   = quot[0];
  assign out_green = quot[1];
  assign out_blue  = quot[2];

endmodule

// ----- src/cmi_select.sv -----
// Stop search and span computation: two pipeline stages.
// Depends on cmi_pkg.
`timescale 1ns / 1ps
module cmi_select #(
  parameter int MAX_STOPS    = 6,
  parameter int SAMPLE_BITS  = 16,
  parameter int CHANNEL_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [SAMPLE_BITS-1:0]        in_sample,
  input  logic                          map_mode,
  input  logic [2:0]                    stop_count,
  input  logic [cmi_pkg::STOP_REGS-1:0][SAMPLE_BITS+3*CHANNEL_BITS-1:0] stops,
  output cmi_pkg::cmi_ctl_t             ctl_o,
  input  logic                          ready_i,
  output logic [2:0][CHANNEL_BITS-1:0]  lo_color_o,
  output logic [2:0][CHANNEL_BITS-1:0]  hi_color_o,
  output logic [SAMPLE_BITS-1:0]        span_o,
  output logic [SAMPLE_BITS-1:0]        offset_o,
  output logic [SAMPLE_BITS-1:0]        remain_o
);

  localparam int STOP_W = SAMPLE_BITS + 3 * CHANNEL_BITS;
  localparam int IW     = cmi_pkg::STOP_IDX_BITS;

  logic [IW-1:0]                n_use;
  logic [IW-1:0]                hi_idx;
  logic [IW-1:0]                lo_sel;
  logic [IW-1:0]                hi_sel;
  logic [cmi_pkg::STOP_REGS-1:0] above;
  logic                         direct_nxt;

  logic                         a_v_r;
  logic                         a_direct_r;
  logic [STOP_W-1:0]            a_lo_r;
  logic [STOP_W-1:0]            a_hi_r;
  logic [SAMPLE_BITS-1:0]       a_s_r;

  logic                         b_v_r;
  logic                         b_direct_r;
  logic [2:0][CHANNEL_BITS-1:0] b_lo_r;
  logic [2:0][CHANNEL_BITS-1:0] b_hi_r;
  logic [SAMPLE_BITS-1:0]       b_span_r;
  logic [SAMPLE_BITS-1:0]       b_off_r;
  logic [SAMPLE_BITS-1:0]       b_rem_r;

  logic                         a_en;
  logic                         b_en;
  logic [SAMPLE_BITS-1:0]       a_plo;
  logic [SAMPLE_BITS-1:0]       a_phi;

  assign b_en     = !b_v_r || ready_i;
  assign a_en     = !a_v_r || b_en;
  assign in_ready = a_en;

  // Stage A: find the first stop in use that lies above the sample.
  always_comb begin
    if (stop_count == 3'd0) begin
      n_use = IW'(1);
    end else if (stop_count > 3'(MAX_STOPS)) begin
      n_use = IW'(MAX_STOPS);
    end else begin
      n_use = stop_count;
    end
    for (int k = 0; k < cmi_pkg::STOP_REGS; k++) begin
      above[k] = (IW'(k) < n_use) && (in_sample < stops[k][STOP_W-1 -: SAMPLE_BITS]);
    end
    hi_idx = n_use;
    for (int k = cmi_pkg::STOP_REGS - 1; k >= 0; k--) begin
      if (above[k]) begin
        hi_idx = IW'(k);
      end
    end
    lo_sel = (hi_idx == '0) ? '0 : hi_idx - IW'(1);
    hi_sel = (hi_idx >= IW'(cmi_pkg::STOP_REGS)) ? IW'(cmi_pkg::STOP_REGS - 1) : hi_idx;
    direct_nxt = (hi_idx == '0) || (hi_idx == n_use) || (map_mode == cmi_pkg::MODE_STEP);
  end

  assign a_plo = a_lo_r[STOP_W-1 -: SAMPLE_BITS];
  assign a_phi = a_hi_r[STOP_W-1 -: SAMPLE_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (a_en) begin
        a_v_r <= in_valid;
      end
      if (b_en) begin
        b_v_r <= a_v_r;
      end
    end
    if (a_en) begin
      a_direct_r <= direct_nxt;
      a_lo_r     <= stops[lo_sel];
      a_hi_r     <= stops[hi_sel];
      a_s_r      <= in_sample;
    end
    // Stage B: span between the stops and the sample's place inside it.
    if (b_en) begin
      b_direct_r <= a_direct_r;
      for (int c = 0; c < 3; c++) begin
        b_lo_r[c] <= a_lo_r[(3 - c) * CHANNEL_BITS - 1 -: CHANNEL_BITS];
        b_hi_r[c] <= a_hi_r[(3 - c) * CHANNEL_BITS - 1 -: CHANNEL_BITS];
      end
      b_span_r <= a_phi - a_plo;
      b_off_r  <= a_s_r - a_plo;
      b_rem_r  <= a_phi - a_s_r;
    end
  end

  assign ctl_o.valid  = b_v_r;
  assign ctl_o.direct = b_direct_r;
  assign lo_color_o   = b_lo_r;
  assign hi_color_o   = b_hi_r;
  assign span_o       = b_span_r;
  assign offset_o     = b_off_r;
  assign remain_o     = b_rem_r;

endmodule

// ----- src/cmi_blend.sv -----
// Weighted color sums: one multiply stage and one rounding-numerator stage.
// Depends on cmi_pkg.
`timescale 1ns / 1ps
module cmi_blend #(
  parameter int SAMPLE_BITS  = 16,
  parameter int CHANNEL_BITS = 8
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  cmi_pkg::cmi_ctl_t                              ctl_i,
  output logic                                           ready_o,
  input  logic [2:0][CHANNEL_BITS-1:0]                   lo_color_i,
  input  logic [2:0][CHANNEL_BITS-1:0]                   hi_color_i,
  input  logic [SAMPLE_BITS-1:0]                         span_i,
  input  logic [SAMPLE_BITS-1:0]                         offset_i,
  input  logic [SAMPLE_BITS-1:0]                         remain_i,
  output cmi_pkg::cmi_ctl_t                              ctl_o,
  input  logic                                           ready_i,
  output logic [2:0][SAMPLE_BITS+CHANNEL_BITS+1:0]       num_o,
  output logic [SAMPLE_BITS-1:0]                         span_o,
  output logic [2:0][CHANNEL_BITS-1:0]                   color_o
);

  localparam int PW = SAMPLE_BITS + CHANNEL_BITS;
  localparam int NW = SAMPLE_BITS + CHANNEL_BITS + 2;

  logic                         c_v_r;
  logic                         c_direct_r;
  logic [2:0][PW-1:0]           c_plo_r;
  logic [2:0][PW-1:0]           c_phi_r;
  logic [SAMPLE_BITS-1:0]       c_span_r;
  logic [2:0][CHANNEL_BITS-1:0] c_col_r;

  logic                         d_v_r;
  logic                         d_direct_r;
  logic [2:0][NW-1:0]           d_num_r;
  logic [SAMPLE_BITS-1:0]       d_span_r;
  logic [2:0][CHANNEL_BITS-1:0] d_col_r;

  logic                         c_en;
  logic                         d_en;
  logic [2:0][PW:0]             sum;

  assign d_en    = !d_v_r || ready_i;
  assign c_en    = !c_v_r || d_en;
  assign ready_o = c_en;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = (PW + 1)'(c_plo_r[c]) + (PW + 1)'(c_phi_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else begin
      if (c_en) begin
        c_v_r <= ctl_i.valid;
      end
      if (d_en) begin
        d_v_r <= c_v_r;
      end
    end
    if (c_en) begin
      c_direct_r <= ctl_i.direct;
      c_span_r   <= span_i;
      c_col_r    <= lo_color_i;
      for (int c = 0; c < 3; c++) begin
        c_plo_r[c] <= PW'(lo_color_i[c]) * PW'(remain_i);
        c_phi_r[c] <= PW'(hi_color_i[c]) * PW'(offset_i);
      end
    end
    // Numerator 2*acc + span, so that the quotient by 2*span rounds halves up.
    if (d_en) begin
      d_direct_r <= c_direct_r;
      d_span_r   <= c_span_r;
      d_col_r    <= c_col_r;
      for (int c = 0; c < 3; c++) begin
        d_num_r[c] <= NW'({sum[c], 1'b0}) + NW'(c_span_r);
      end
    end
  end

  assign ctl_o.valid  = d_v_r;
  assign ctl_o.direct = d_direct_r;
  assign num_o        = d_num_r;
  assign span_o       = d_span_r;
  assign color_o      = d_col_r;

endmodule

// ----- src/cmi_div.sv -----
// Pipelined restoring divider, one quotient bit per stage for all three channels.
// The last stage holds the result request. Depends on cmi_pkg.
`timescale 1ns / 1ps
module cmi_div #(
  parameter int SAMPLE_BITS  = 16,
  parameter int CHANNEL_BITS = 8
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  cmi_pkg::cmi_ctl_t                        ctl_i,
  output logic                                     ready_o,
  input  logic [2:0][SAMPLE_BITS+CHANNEL_BITS+1:0] num_i,
  input  logic [SAMPLE_BITS-1:0]                   span_i,
  input  logic [2:0][CHANNEL_BITS-1:0]             color_i,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [2:0][CHANNEL_BITS-1:0]             quot_o
);

  localparam int NW = SAMPLE_BITS + CHANNEL_BITS + 2;
  localparam int ST = CHANNEL_BITS;

  logic [ST-1:0]                v_r;
  logic [ST-1:0]                dir_r;
  logic [ST-1:0]                en;
  logic [SAMPLE_BITS-1:0]       span_r [ST];
  logic [2:0][NW-1:0]           rem_r  [ST];
  logic [2:0][CHANNEL_BITS-1:0] q_r    [ST];

  for (genvar j = 0; j < ST; j++) begin : g_stage
    logic                         sv;
    logic                         sd;
    logic [SAMPLE_BITS-1:0]       ssp;
    logic [2:0][NW-1:0]           srem;
    logic [2:0][CHANNEL_BITS-1:0] sq;
    logic [NW-1:0]                den_sh;
    logic [2:0][NW-1:0]           rem_nxt;
    logic [2:0][CHANNEL_BITS-1:0] q_nxt;

    if (j == 0) begin : g_first
      // Items that need no blend enter with their stop color as the quotient.
      assign sv   = ctl_i.valid;
      assign sd   = ctl_i.direct;
      assign ssp  = span_i;
      assign srem = num_i;
      assign sq   = ctl_i.direct ? color_i : '0;
    end else begin : g_next
      assign sv   = v_r[j-1];
      assign sd   = dir_r[j-1];
      assign ssp  = span_r[j-1];
      assign srem = rem_r[j-1];
      assign sq   = q_r[j-1];
    end

    if (j == ST - 1) begin : g_last_en
      assign en[j] = !v_r[j] || out_ready;
    end else begin : g_mid_en
      assign en[j] = !v_r[j] || en[j+1];
    end

    always_comb begin
      den_sh  = NW'({ssp, 1'b0}) << (ST - 1 - j);
      rem_nxt = srem;
      q_nxt   = sq;
      for (int c = 0; c < 3; c++) begin
        if (!sd && (srem[c] >= den_sh)) begin
          rem_nxt[c]         = srem[c] - den_sh;
          q_nxt[c][ST-1-j]   = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en[j]) begin
        v_r[j] <= sv;
      end
      if (en[j]) begin
        dir_r[j]  <= sd;
        span_r[j] <= ssp;
        rem_r[j]  <= rem_nxt;
        q_r[j]    <= q_nxt;
      end
    end
  end

  assign ready_o   = en[0];
  assign out_valid = v_r[ST-1];
  assign quot_o    = q_r[ST-1];

endmodule

// ----- src/cmi_checker.sv -----
// Port-level checks for the color map interpolator, bound to the top level.
// Depends only on the ports of color_map_interpolator_core.
`timescale 1ns / 1ps
module cmi_checker #(
  parameter int CHANNEL_BITS = 8
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [CHANNEL_BITS-1:0] out_red,
  input logic [CHANNEL_BITS-1:0] out_green,
  input logic [CHANNEL_BITS-1:0] out_blue,
  input logic                    cfg_ready
);

  // A stalled result request keeps its color.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) &&
                                $stable(out_green) && $stable(out_blue))
    else $error("result changed or dropped while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present right after reset");

  // When the consumer takes results, every stage can advance, so input is taken.
  a_no_block: assert property (@(posedge clk)
    out_ready |-> in_ready)
    else $error("input blocked while output is free");

  // Configuration writes are always taken.
  a_cfg_ready: assert property (@(posedge clk)
    cfg_ready)
    else $error("configuration port not ready");

  // Input is only refused while a result waits.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |-> out_valid && !out_ready)
    else $error("input refused without output back-pressure");

endmodule

bind color_map_interpolator_core cmi_checker #(
  .CHANNEL_BITS(CHANNEL_BITS)
) u_cmi_checker (.*);
